### hw/rtl/mcbp_pkg.sv
package mcbp_pkg;

    localparam int VALUE_DIGITS = 4;
    localparam int COORD_BITS   = 32;
    localparam int DIGIT_BITS   = 7;
    localparam int VALUE_BITS   = 28;
    localparam int FEED_BITS    = 27;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 28;
    localparam logic [FEED_BITS-1:0] DEFAULT_FEED = 27'd8000000;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_FEED = 2'd3;

    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_LINE    = 4'd1;
    localparam logic [3:0] EV_RASTER  = 4'd2;
    localparam logic [3:0] EV_DWELL   = 4'd3;
    localparam logic [3:0] EV_HOMING  = 4'd4;
    localparam logic [3:0] EV_AIR_ON  = 4'd5;
    localparam logic [3:0] EV_AIR_OFF = 4'd6;
    localparam logic [3:0] EV_AUX_ON  = 4'd7;
    localparam logic [3:0] EV_AUX_OFF = 4'd8;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_MARKER  = 3'd1;
    localparam logic [2:0] ERR_DATA    = 3'd2;
    localparam logic [2:0] ERR_COMMAND = 3'd3;
    localparam logic [2:0] ERR_PARAM   = 3'd4;

    typedef struct packed {
        logic [7:0]         rx_byte;
        logic               stop_active;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         event_res;
        logic [2:0]         error_code;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
        logic signed [27:0] move_feed;
        logic [7:0]         move_power;
        logic signed [27:0] move_extra;
    } out_item_t;

endpackage

### hw/rtl/mcbp_core.sv
module mcbp_core #(
    parameter int COORD_BITS = mcbp_pkg::COORD_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [mcbp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mcbp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                step,
    input  mcbp_pkg::in_item_t  item,
    output mcbp_pkg::out_item_t result
);

    localparam int W = ((COORD_BITS > 32) ? COORD_BITS : 32) + 2;
    localparam logic signed [W-1:0] CMAX = W'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [W-1:0] CMIN = -W'(64'sd1 <<< (COORD_BITS-1));
    localparam logic [18:0] PWR_RECIP = 19'd268436;
    localparam logic signed [27:0] PWR_SAT_AT = 28'sd256000;

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [W-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (v > CMAX) r = CMAX[COORD_BITS-1:0];
        else if (v < CMIN) r = CMIN[COORD_BITS-1:0];
        else r = v[COORD_BITS-1:0];
        return r;
    endfunction

    logic signed [27:0] origin_reg [3];
    logic [6:0] dig_reg [4];
    logic [2:0] cnt_reg, cnt_next;
    logic abs_reg, abs_next, smode_reg, smode_next;
    logic signed [27:0] feed_reg, feed_next, dwell_reg, dwell_next, rstep_reg, rstep_next;
    logic [7:0] pwr_reg, pwr_next;
    logic signed [COORD_BITS-1:0] tgt_reg [3], tgt_next [3];
    logic signed [COORD_BITS-1:0] uoff_reg [3], uoff_next [3];
    logic signed [COORD_BITS-1:0] soff_reg [3], soff_next [3];
    logic dwr;

    logic [7:0] c;
    logic signed [27:0] v;
    logic signed [W-1:0] posw [3];
    logic [1:0] ax;
    logic [36:0] qprod;
    logic [7:0] pwr_calc;
    logic [2:0] err;
    logic signed [W-1:0] sum;

    assign c = item.rx_byte;
    assign v = $signed({dig_reg[3], dig_reg[2], dig_reg[1], dig_reg[0]} ^ 28'h8000000);
    assign posw[0] = W'(item.pos_x);
    assign posw[1] = W'(item.pos_y);
    assign posw[2] = W'(item.pos_z);
    assign ax = (c == "x" || c == "h") ? 2'd0 : ((c == "y" || c == "i") ? 2'd1 : 2'd2);
    // v / 1000 by reciprocal multiply, exact over 0..255999
    assign qprod = {19'd0, v[17:0]} * {18'd0, PWR_RECIP};
    assign pwr_calc = (v < 0) ? 8'd0 : ((v >= PWR_SAT_AT) ? 8'd255 : qprod[35:28]);

    always_comb
    begin
        cnt_next = cnt_reg; abs_next = abs_reg; smode_next = smode_reg;
        feed_next = feed_reg; pwr_next = pwr_reg; dwell_next = dwell_reg;
        rstep_next = rstep_reg; dwr = 1'b0; err = mcbp_pkg::ERR_OK;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            tgt_next[k] = tgt_reg[k]; uoff_next[k] = uoff_reg[k]; soff_next[k] = soff_reg[k];
        end
        result = '0;
        if (item.stop_active)
        begin
            cnt_next = '0;
        end
        else if (c[7])
        begin
            if (cnt_reg < 3'(mcbp_pkg::VALUE_DIGITS))
            begin
                dwr = 1'b1;
                cnt_next = cnt_reg + 3'd1;
            end
            else
                err = mcbp_pkg::ERR_DATA;
        end
        else if (c >= "A" && c <= "Z")
        begin
            cnt_next = '0;
            unique case (c)
                "A": ;
                "B", "D":
                begin
                    result.event_res = (c == "B") ? mcbp_pkg::EV_LINE : mcbp_pkg::EV_RASTER;
                    result.move_x = 32'(tgt_reg[0]);
                    result.move_y = 32'(tgt_reg[1]);
                    result.move_z = 32'(tgt_reg[2]);
                    result.move_feed = feed_reg;
                    result.move_power = pwr_reg;
                    result.move_extra = (c == "D") ? rstep_reg : '0;
                end
                "C":
                begin
                    result.event_res = mcbp_pkg::EV_DWELL;
                    result.move_power = pwr_reg;
                    result.move_extra = dwell_reg;
                end
                "E": abs_next = 1'b0;
                "F": abs_next = 1'b1;
                "G": smode_next = abs_reg;
                "H": abs_next = smode_reg;
                "I":
                begin
                    result.event_res = mcbp_pkg::EV_HOMING;
                    for (int k = 0; k < 3; k++)
                    begin
                        uoff_next[k] = '0;
                        tgt_next[k] = sat(W'(origin_reg[k]));
                    end
                    result.move_x = 32'(tgt_next[0]);
                    result.move_y = 32'(tgt_next[1]);
                    result.move_z = 32'(tgt_next[2]);
                    result.move_feed = feed_reg;
                end
                "J": for (int k = 0; k < 3; k++) soff_next[k] = uoff_reg[k];
                "K": for (int k = 0; k < 3; k++) uoff_next[k] = soff_reg[k];
                "L": result.event_res = mcbp_pkg::EV_AIR_ON;
                "M": result.event_res = mcbp_pkg::EV_AIR_OFF;
                "N": result.event_res = mcbp_pkg::EV_AUX_ON;
                "O": result.event_res = mcbp_pkg::EV_AUX_OFF;
                default: err = mcbp_pkg::ERR_COMMAND;
            endcase
        end
        else if (c >= "a" && c <= "z")
        begin
            cnt_next = '0;
            if (cnt_reg != 3'(mcbp_pkg::VALUE_DIGITS))
                err = mcbp_pkg::ERR_DATA;
            else
            begin
                unique case (c)
                    "x", "y", "z":
                    begin
                        if (abs_reg)
                            sum = W'(v) + W'(origin_reg[ax]) + W'(uoff_reg[ax]);
                        else
                            sum = W'(tgt_reg[ax]) + W'(v);
                        tgt_next[ax] = sat(sum);
                    end
                    "f": feed_next = v;
                    "s": pwr_next = pwr_calc;
                    "d": dwell_next = v;
                    "p": rstep_next = v;
                    "h", "i", "j":
                    begin
                        if (abs_reg)
                            sum = W'(v);
                        else
                            sum = posw[ax] - W'(origin_reg[ax]) + W'(v);
                        uoff_next[ax] = sat(sum);
                    end
                    default: err = mcbp_pkg::ERR_PARAM;
                endcase
            end
        end
        else
        begin
            err = mcbp_pkg::ERR_MARKER;
            cnt_next = '0;
        end
        if (err != mcbp_pkg::ERR_OK)
        begin
            result = '0;
            result.error_code = err;
            cnt_next = '0;
            abs_next = abs_reg; smode_next = smode_reg; feed_next = feed_reg;
            pwr_next = pwr_reg; dwell_next = dwell_reg; rstep_next = rstep_reg;
            dwr = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                uoff_next[k] = uoff_reg[k]; soff_next[k] = soff_reg[k];
            end
        end
        if (item.stop_active || err != mcbp_pkg::ERR_OK)
            for (int k = 0; k < 3; k++) tgt_next[k] = sat(posw[k]);
    end

    always_ff @(posedge clk)
        if (step && dwr)
            dig_reg[cnt_reg[1:0]] <= c[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                origin_reg[k] <= '0; tgt_reg[k] <= '0; uoff_reg[k] <= '0; soff_reg[k] <= '0;
            end
            cnt_reg <= '0; abs_reg <= 1'b1; smode_reg <= 1'b0;
            feed_reg <= 28'(mcbp_pkg::DEFAULT_FEED);
            pwr_reg <= '0; dwell_reg <= '0; rstep_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mcbp_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                    mcbp_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                    mcbp_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                    mcbp_pkg::REG_DEFAULT_FEED: ;
                    default: ;
                endcase
            end
            if (step)
            begin
                cnt_reg <= cnt_next; abs_reg <= abs_next; smode_reg <= smode_next;
                feed_reg <= feed_next; pwr_reg <= pwr_next; dwell_reg <= dwell_next;
                rstep_reg <= rstep_next;
                for (int k = 0; k < 3; k++)
                begin
                    tgt_reg[k] <= tgt_next[k]; uoff_reg[k] <= uoff_next[k];
                    soff_reg[k] <= soff_next[k];
                end
            end
        end
    end

endmodule

### hw/rtl/motion_command_byte_parser.sv
// an accepted request passes from the input register in_reg to the result register out_data
// throughput: one byte per cycle while the result is not stalled, set by the single-pass parse logic
// an input register and one skid entry hold requests behind a stalled result
// reset: asynchronous active-low rst_n clears all control state
// after reset target is the origin, mode absolute, feed the default feed
module motion_command_byte_parser #(
    parameter int COORD_BITS = mcbp_pkg::COORD_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mcbp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mcbp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [mcbp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mcbp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    mcbp_pkg::in_item_t  in_reg;
    logic                inv_reg;
    mcbp_pkg::out_item_t res;
    logic                skv_reg;
    logic                step;

    assign cfg_ready = 1'b1;
    assign in_stall = skv_reg;
    // item in in_reg is processed when the result register can take it
    assign step = inv_reg && !(out_valid && out_stall);

    mcbp_core #(.COORD_BITS(COORD_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .step(step), .item(in_reg), .result(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0; out_valid <= 1'b0; skv_reg <= 1'b0;
        end
        else
        begin
            out_valid <= step || (out_valid && out_stall);
            if (skv_reg)
            begin
                if (!(inv_reg && !step))
                    skv_reg <= 1'b0;
            end
            if (in_valid && !in_stall)
            begin
                if (inv_reg && !step)
                    skv_reg <= 1'b1;
                else
                    inv_reg <= 1'b1;
            end
            else if (skv_reg && !(inv_reg && !step))
                inv_reg <= 1'b1;
            else if (step)
                inv_reg <= 1'b0;
        end
    end

    mcbp_pkg::in_item_t skin_reg;

    always_ff @(posedge clk)
    begin
        if (step)
            out_data <= res;
        if (in_valid && !in_stall)
        begin
            if (inv_reg && !step)
                skin_reg <= in_data;
            else
                in_reg <= in_data;
        end
        else if (skv_reg && !(inv_reg && !step))
            in_reg <= skin_reg;
    end

endmodule

### hw/rtl/mcbp_checker.sv
module mcbp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input mcbp_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    a_event_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != mcbp_pkg::ERR_OK
            |-> out_data.event_res == mcbp_pkg::EV_NONE)
        else $error("event with error");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_res <= mcbp_pkg::EV_AUX_OFF)
        else $error("bad event code");

    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall && !$past(out_stall) |=> !in_stall)
        else $error("input stall stuck");

endmodule

bind motion_command_byte_parser mcbp_checker u_mcbp_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
